FILE: design/psa_pkg.sv
// Shared types, codes and constants for the paged sequence page allocator.
// No dependencies.
package psa_pkg;

  localparam int unsigned POOL_PAGES_DEF  = 1024;
  localparam int unsigned TABLE_SLOTS_DEF = 256;
  localparam int unsigned MAX_RUN_DEF     = 64;

  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT = 33;
  localparam logic [63:0] KEY_EMPTY = 64'h8000000000000000;
  localparam logic [63:0] KEY_TOMB  = 64'h8000000000000001;

  localparam int unsigned PAGE_IDX_W = 10;
  localparam int unsigned FREE_W     = 11;
  localparam int unsigned ACTIVE_W   = 9;
  localparam int unsigned COUNT_W    = 7;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_LIST    = 2'd2,
    ACT_BAD     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_FEW   = 3'd1,
    ST_TABLE_FUL = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_LIMIT     = 3'd4
  } status_e;

  typedef struct packed {
    action_e            op;
    logic               bad;
    logic [63:0]        key;
    logic [COUNT_W-1:0] count;
    logic               limit_given;
    logic [COUNT_W-1:0] limit;
  } item_t;

  typedef struct packed {
    status_e               status;
    logic                  page_valid;
    logic [PAGE_IDX_W-1:0] page_index;
    logic                  last;
    logic                  new_sequence;
    logic [FREE_W-1:0]     free_pages;
    logic [ACTIVE_W-1:0]   live_seqs;
  } res_t;

endpackage

FILE: design/psa_front.sv
// Front end: takes request beats, flags reserved keys and bad actions,
// and queues them for the engine. Depends on psa_pkg.
module psa_front
  import psa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                init_done_i,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          action_i,
  input  logic signed [63:0]  sequence_id_i,
  input  logic [COUNT_W-1:0]  page_count_i,
  input  logic                limit_given_i,
  input  logic [COUNT_W-1:0]  list_limit_i,
  output logic                item_valid_o,
  output item_t               item_o,
  input  logic                item_pop_i
);

  item_t       ent_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  item_t       item_in;
  logic        do_push;

  always_comb begin
    item_in.op          = action_e'(action_i);
    item_in.key         = sequence_id_i;
    item_in.bad         = (sequence_id_i == KEY_EMPTY) || (sequence_id_i == KEY_TOMB) ||
                          (action_i == ACT_BAD);
    item_in.count       = page_count_i;
    item_in.limit_given = limit_given_i;
    item_in.limit       = list_limit_i;
  end

  assign full         = (cnt_q == 2'd2) || !init_done_i;
  assign do_push      = push && !full;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (item_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(item_pop_i);
    end
  end

endmodule

FILE: design/psa_outq.sv
// Result queue between the engine and the result port.
// Depends on psa_pkg.
module psa_outq
  import psa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_push_i,
  input  res_t res_i,
  output logic res_full_o,
  input  logic pop,
  output logic empty,
  output res_t res_o
);

  res_t       ent_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       do_pop;

  assign empty      = (cnt_q == 3'd0);
  assign res_full_o = (cnt_q == 3'd4);
  assign do_pop     = pop && !empty;
  assign res_o      = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      ent_q[wp_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (res_push_i) wp_q <= wp_q + 2'd1;
      if (do_pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(res_push_i) - 3'(do_pop);
    end
  end

endmodule

FILE: design/psa_engine.sv
// Back end: hash, table probe, page stack and chain walks, result beats.
// Depends on psa_pkg; fed by psa_front, drains into psa_outq.
module psa_engine
  import psa_pkg::*;
#(
  parameter int unsigned POOL_PAGES  = POOL_PAGES_DEF,
  parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int unsigned MAX_RUN     = MAX_RUN_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  output logic  init_done_o,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  item_pop_o,
  input  logic  res_full_i,
  output logic  res_push_o,
  output res_t  res_o
);

  localparam int unsigned PW   = $clog2(POOL_PAGES);
  localparam int unsigned PLW  = PW + 1;
  localparam int unsigned FW   = $clog2(POOL_PAGES + 1);
  localparam int unsigned SW   = $clog2(TABLE_SLOTS);
  localparam int unsigned LW   = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned RW   = SW + 1;
  localparam int unsigned CMPW = FW + COUNT_W;
  localparam logic [PLW-1:0] NO_PAGE = PLW'(POOL_PAGES);
  localparam bit POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

  typedef enum logic [18:0] {
    S_INIT    = 19'h00001,
    S_IDLE    = 19'h00002,
    S_MIX     = 19'h00004,
    S_MUL     = 19'h00008,
    S_MOD     = 19'h00010,
    S_PRD     = 19'h00020,
    S_PCMP    = 19'h00040,
    S_META    = 19'h00080,
    S_DISP    = 19'h00100,
    S_ACQ_RD  = 19'h00200,
    S_ACQ_LNK = 19'h00400,
    S_ACQ_APP = 19'h00800,
    S_WB      = 19'h01000,
    S_REL     = 19'h02000,
    S_REL_WR  = 19'h04000,
    S_REL_END = 19'h08000,
    S_LST     = 19'h10000,
    S_LST_EM  = 19'h20000,
    S_ONE     = 19'h40000
  } state_e;

  logic [PW-1:0]  stack_mem [POOL_PAGES];
  logic [PLW-1:0] link_mem  [POOL_PAGES];
  logic [63:0]    key_mem   [TABLE_SLOTS];
  logic [PLW-1:0] head_mem  [TABLE_SLOTS];
  logic [PLW-1:0] tail_mem  [TABLE_SLOTS];
  logic [FW-1:0]  tot_mem   [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] kvld_q;

  state_e             state_q, state_d;
  item_t              it_q, it_d;
  logic [63:0]        x_q, x_d, acc_q, acc_d, prod_q;
  logic [1:0]         mstep_q, mstep_d, hs_q, hs_d;
  logic [5:0]         bc_q, bc_d;
  logic [RW-1:0]      rem_q, rem_d;
  logic [SW-1:0]      idx_q, idx_d, tomb_q, tomb_d, slot_q, slot_d;
  logic               tomb_v_q, tomb_v_d, new_q, new_d;
  logic [LW-1:0]      pc_q, pc_d, live_q, live_d;
  logic [PLW-1:0]     head_q, head_d, tail_q, tail_d, pg_q, pg_d;
  logic [FW-1:0]      tot_q, tot_d, free_q, free_d;
  logic [PW-1:0]      ptr_q, ptr_d, init_q, init_d;
  logic [COUNT_W-1:0] i_q, i_d, n_q, n_d, want_q, want_d;
  status_e            status_q, status_d;

  logic [PW-1:0]  stk_rd_q;
  logic [PLW-1:0] link_rd_q, head_rd_q, tail_rd_q;
  logic [63:0]    key_rd_q;
  logic           kv_rd_q;
  logic [FW-1:0]  tot_rd_q;

  logic           stk_we, link_we, key_we, meta_we;
  logic [PW-1:0]  stk_wa, stk_wd, link_wa;
  logic [PLW-1:0] link_wd, head_wd, tail_wd;
  logic [SW-1:0]  key_wa;
  logic [63:0]    key_wd;
  logic [FW-1:0]  tot_wd;

  logic [31:0]    mul_a, mul_b;
  logic [63:0]    mconst, kcur;
  logic [RW-1:0]  rmod;
  logic [SW:0]    idx_inc;
  logic [SW-1:0]  target;
  logic [CMPW-1:0] want_w;
  logic           acq_last, lst_last;

  assign init_done_o = (state_q != S_INIT);
  assign mconst  = (hs_q == 2'd1) ? MIX_C1 : MIX_C2;
  assign mul_a   = (mstep_q == 2'd2) ? x_q[63:32] : x_q[31:0];
  assign mul_b   = (mstep_q == 2'd1) ? mconst[63:32] : mconst[31:0];
  assign kcur    = kv_rd_q ? key_rd_q : KEY_EMPTY;
  assign idx_inc = {1'b0, idx_q} + 1'b1;
  assign acq_last = ((i_q + 1'b1) == it_q.count);
  assign lst_last = ((n_q + 1'b1) == want_q) || (link_rd_q >= NO_PAGE);

  always_comb begin
    state_d = state_q;   it_d = it_q;     x_d = x_q;       acc_d = acc_q;
    mstep_d = mstep_q;   hs_d = hs_q;     bc_d = bc_q;     rem_d = rem_q;
    idx_d = idx_q;       tomb_d = tomb_q; slot_d = slot_q; tomb_v_d = tomb_v_q;
    new_d = new_q;       pc_d = pc_q;     live_d = live_q; head_d = head_q;
    tail_d = tail_q;     pg_d = pg_q;     tot_d = tot_q;   free_d = free_q;
    ptr_d = ptr_q;       init_d = init_q; i_d = i_q;       n_d = n_q;
    want_d = want_q;     status_d = status_q;
    stk_we = 1'b0;  stk_wa = '0;   stk_wd = '0;
    link_we = 1'b0; link_wa = '0;  link_wd = NO_PAGE;
    key_we = 1'b0;  key_wa = slot_q; key_wd = KEY_TOMB;
    meta_we = 1'b0; head_wd = head_q; tail_wd = tail_q; tot_wd = tot_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o.status       = ST_OK;
    res_o.page_valid   = 1'b0;
    res_o.page_index   = '0;
    res_o.last         = 1'b1;
    res_o.new_sequence = 1'b0;
    res_o.free_pages   = FREE_W'(free_q);
    res_o.live_seqs    = ACTIVE_W'(live_q);
    target = tomb_v_q ? tomb_q : idx_q;
    want_w = '0;
    rmod   = rem_q;

    unique case (state_q)
      S_INIT: begin
        stk_we = 1'b1;
        stk_wa = init_q;
        stk_wd = PW'(POOL_PAGES - 1) - init_q;
        init_d = init_q + 1'b1;
        if (init_q == PW'(POOL_PAGES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          it_d  = item_i;
          x_d   = item_i.key;
          hs_d  = 2'd0;
          new_d = 1'b0;
          status_d = ST_OK;
          if (item_i.bad) begin
            status_d = ST_NOT_FOUND;
            state_d  = S_ONE;
          end else if (item_i.op == ACT_ACQUIRE) begin
            if (item_i.count == '0) begin
              state_d = S_ONE;
            end else if (item_i.count > COUNT_W'(MAX_RUN) ||
                         CMPW'(free_q) < CMPW'(item_i.count)) begin
              status_d = ST_TOO_FEW;
              state_d  = S_ONE;
            end else begin
              state_d = S_MIX;
            end
          end else begin
            state_d = S_MIX;
          end
        end
      end
      S_MIX: begin
        x_d  = x_q ^ (x_q >> MIX_SHIFT);
        hs_d = hs_q + 2'd1;
        mstep_d = 2'd0;
        if (hs_q == 2'd2) begin
          pc_d = '0;
          tomb_v_d = 1'b0;
          bc_d = '0;
          rem_d = '0;
          if (POW2) begin
            idx_d   = x_d[SW-1:0];
            state_d = S_PRD;
          end else begin
            state_d = S_MOD;
          end
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd1) acc_d = prod_q;
        if (mstep_q == 2'd2) acc_d = acc_q + {prod_q[31:0], 32'd0};
        if (mstep_q == 2'd3) begin
          x_d = acc_q + {prod_q[31:0], 32'd0};
          state_d = S_MIX;
        end
      end
      S_MOD: begin
        // four remainder bits a cycle, all 64 key bits shifted through
        for (int b = 0; b < 4; b++) begin
          rmod = {rmod[RW-2:0], x_q[63-b]};
          if (rmod >= RW'(TABLE_SLOTS)) rmod = rmod - RW'(TABLE_SLOTS);
        end
        x_d   = {x_q[59:0], 4'd0};
        bc_d  = bc_q + 1'b1;
        rem_d = rmod;
        if (bc_q == 6'd15) begin
          idx_d   = rmod[SW-1:0];
          state_d = S_PRD;
        end
      end
      S_PRD: state_d = S_PCMP;
      S_PCMP: begin
        if (pc_q == LW'(TABLE_SLOTS) || kcur == KEY_EMPTY) begin
          if (it_q.op == ACT_ACQUIRE && (tomb_v_q || pc_q != LW'(TABLE_SLOTS))) begin
            slot_d = target;
            key_we = 1'b1;
            key_wa = target;
            key_wd = it_q.key;
            head_d = NO_PAGE;
            tail_d = NO_PAGE;
            tot_d  = '0;
            new_d  = 1'b1;
            live_d = live_q + 1'b1;
            free_d = free_q - FW'(it_q.count);
            ptr_d  = free_d[PW-1:0];
            i_d    = '0;
            state_d = S_ACQ_RD;
          end else begin
            status_d = (it_q.op == ACT_ACQUIRE) ? ST_TABLE_FUL : ST_NOT_FOUND;
            state_d  = S_ONE;
          end
        end else if (kcur == it_q.key) begin
          slot_d  = idx_q;
          state_d = S_META;
        end else begin
          if (kcur == KEY_TOMB && !tomb_v_q) begin
            tomb_v_d = 1'b1;
            tomb_d   = idx_q;
          end
          idx_d   = (idx_inc == (SW + 1)'(TABLE_SLOTS)) ? '0 : idx_inc[SW-1:0];
          pc_d    = pc_q + 1'b1;
          state_d = S_PRD;
        end
      end
      S_META: state_d = S_DISP;
      S_DISP: begin
        head_d = head_rd_q;
        tail_d = tail_rd_q;
        tot_d  = tot_rd_q;
        pg_d   = head_rd_q;
        n_d    = '0;
        unique case (it_q.op)
          ACT_ACQUIRE: begin
            free_d = free_q - FW'(it_q.count);
            ptr_d  = free_d[PW-1:0];
            i_d    = '0;
            state_d = S_ACQ_RD;
          end
          ACT_RELEASE: state_d = S_REL;
          default: begin
            if (it_q.limit_given && CMPW'(it_q.limit) > CMPW'(tot_rd_q)) begin
              status_d = ST_LIMIT;
              state_d  = S_ONE;
            end else begin
              want_w = it_q.limit_given ? CMPW'(it_q.limit) : CMPW'(tot_rd_q);
              if (want_w > CMPW'(MAX_RUN)) want_w = CMPW'(MAX_RUN);
              want_d  = want_w[COUNT_W-1:0];
              state_d = S_LST;
            end
          end
        endcase
      end
      S_ACQ_RD: state_d = S_ACQ_LNK;
      S_ACQ_LNK: begin
        link_we = 1'b1;
        link_wa = stk_rd_q;
        pg_d    = {1'b0, stk_rd_q};
        state_d = S_ACQ_APP;
      end
      S_ACQ_APP: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.page_valid   = 1'b1;
          res_o.page_index   = PAGE_IDX_W'(pg_q);
          res_o.last         = acq_last;
          res_o.new_sequence = new_q;
          if (tail_q < NO_PAGE) begin
            link_we = 1'b1;
            link_wa = tail_q[PW-1:0];
            link_wd = pg_q;
          end
          if (head_q >= NO_PAGE) head_d = pg_q;
          tail_d = pg_q;
          tot_d  = tot_q + 1'b1;
          i_d    = i_q + 1'b1;
          ptr_d  = ptr_q + 1'b1;
          state_d = acq_last ? S_WB : S_ACQ_RD;
        end
      end
      S_WB: begin
        meta_we = 1'b1;
        state_d = S_IDLE;
      end
      S_REL: state_d = (pg_q >= NO_PAGE) ? S_REL_END : S_REL_WR;
      S_REL_WR: begin
        link_we = 1'b1;
        link_wa = pg_q[PW-1:0];
        stk_we  = 1'b1;
        stk_wa  = free_q[PW-1:0];
        stk_wd  = pg_q[PW-1:0];
        free_d  = free_q + 1'b1;
        pg_d    = link_rd_q;
        state_d = S_REL;
      end
      S_REL_END: begin
        key_we  = 1'b1;
        meta_we = 1'b1;
        head_wd = NO_PAGE;
        tail_wd = NO_PAGE;
        tot_wd  = '0;
        if (live_q != '0) live_d = live_q - 1'b1;
        state_d = S_ONE;
      end
      S_LST: state_d = (pg_q >= NO_PAGE || want_q == '0) ? S_ONE : S_LST_EM;
      S_LST_EM: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.page_valid = 1'b1;
          res_o.page_index = PAGE_IDX_W'(pg_q);
          res_o.last       = lst_last;
          pg_d    = link_rd_q;
          n_d     = n_q + 1'b1;
          state_d = lst_last ? S_IDLE : S_LST;
        end
      end
      S_ONE: begin
        if (!res_full_i) begin
          res_push_o   = 1'b1;
          res_o.status = status_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= mul_a * mul_b;
    stk_rd_q  <= stack_mem[ptr_q];
    link_rd_q <= link_mem[pg_q[PW-1:0]];
    key_rd_q  <= key_mem[idx_q];
    kv_rd_q   <= kvld_q[idx_q];
    head_rd_q <= head_mem[slot_q];
    tail_rd_q <= tail_mem[slot_q];
    tot_rd_q  <= tot_mem[slot_q];
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (key_we) key_mem[key_wa] <= key_wd;
    if (meta_we) begin
      head_mem[slot_q] <= head_wd;
      tail_mem[slot_q] <= tail_wd;
      tot_mem[slot_q]  <= tot_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d;     x_q <= x_d;         acc_q <= acc_d;   mstep_q <= mstep_d;
    hs_q <= hs_d;     bc_q <= bc_d;       rem_q <= rem_d;   idx_q <= idx_d;
    tomb_q <= tomb_d; slot_q <= slot_d;   tomb_v_q <= tomb_v_d;
    new_q <= new_d;   pc_q <= pc_d;       head_q <= head_d; tail_q <= tail_d;
    pg_q <= pg_d;     tot_q <= tot_d;     ptr_q <= ptr_d;   i_q <= i_d;
    n_q <= n_d;       want_q <= want_d;   status_q <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      init_q  <= '0;
      free_q  <= FW'(POOL_PAGES);
      live_q  <= '0;
      kvld_q  <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      free_q  <= free_d;
      live_q  <= live_d;
      if (key_we) kvld_q[key_wa] <= 1'b1;
    end
  end

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FW'(POOL_PAGES)) else $error("free count above pool size");
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= LW'(TABLE_SLOTS)) else $error("live count above table size");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i) else $error("result beat into full queue");
  a_acq_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACQ_APP && res_push_o && res_o.last) |=> state_q == S_WB)
    else $error("acquire ended without slot write-back");

endmodule

FILE: design/paged_sequence_page_allocator.sv
// Top level of the paged sequence page allocator: front queue, engine and
// result queue. Depends on psa_pkg, psa_front, psa_engine and psa_outq.
//
// Requests enter as queue pushes (push/full) and results leave as queue pops
// (empty/pop). Acquire answers one beat per page handed out, list one beat
// per page listed, release, every error and a request with no page to hand
// out or list one beat; the final beat of a request has last set. Every
// beat carries the free page and live sequence counts after the request.
// After reset the engine loads the free-page stack, one entry a cycle, and
// full stays high until the load is done.
// Steps of a request that passes the first checks: the key hash (plus a
// remainder step at four bits a cycle when TABLE_SLOTS is not a power of
// two), the table probes, the slot read when the key is found, then the
// acquired, released or listed pages in turn, each bounded by the stack
// and link RAMs.
// Requests are worked one at a time; two may wait in the front queue and
// four result beats in the result queue. When the receiver stops popping,
// the engine stalls once the result queue fills, and the front queue keeps
// taking requests until it is full.
module paged_sequence_page_allocator
  import psa_pkg::*;
#(
  parameter int unsigned POOL_PAGES  = POOL_PAGES_DEF,
  parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int unsigned MAX_RUN     = MAX_RUN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            action_i,
  input  logic signed [63:0]    sequence_id_i,
  input  logic [COUNT_W-1:0]    page_count_i,
  input  logic                  limit_given_i,
  input  logic [COUNT_W-1:0]    list_limit_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [2:0]            status_o,
  output logic                  page_valid_o,
  output logic [PAGE_IDX_W-1:0] page_index_o,
  output logic                  last_o,
  output logic                  new_sequence_o,
  output logic [FREE_W-1:0]     free_pages_o,
  output logic [ACTIVE_W-1:0]   live_seqs_o
);

  logic  init_done, item_valid, item_pop, res_full, res_push;
  item_t item;
  res_t  res_in, res_out;

  psa_front u_front (
    .clk_i, .rst_ni,
    .init_done_i  (init_done),
    .push, .full,
    .action_i, .sequence_id_i, .page_count_i, .limit_given_i, .list_limit_i,
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  psa_engine #(
    .POOL_PAGES  (POOL_PAGES),
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_RUN     (MAX_RUN)
  ) u_engine (
    .clk_i, .rst_ni,
    .init_done_o  (init_done),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  psa_outq u_outq (
    .clk_i, .rst_ni,
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .pop, .empty,
    .res_o      (res_out)
  );

  assign status_o       = res_out.status;
  assign page_valid_o   = res_out.page_valid;
  assign page_index_o   = res_out.page_index;
  assign last_o         = res_out.last;
  assign new_sequence_o = res_out.new_sequence;
  assign free_pages_o   = res_out.free_pages;
  assign live_seqs_o    = res_out.live_seqs;

endmodule

FILE: verif/paged_sequence_page_allocator_test.sv
// Testbench for paged_sequence_page_allocator: directed table, random traffic and a
// table fill, every beat checked against an in-bench page/sequence table predictor.
// Depends on psa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module paged_sequence_page_allocator_test;
  import psa_pkg::*;

  localparam int NPG = POOL_PAGES_DEF;
  localparam int NSLOT = TABLE_SLOTS_DEF;
  localparam int RUNMAX = MAX_RUN_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int NONE = -1;

  typedef struct {
    action_e     op;
    logic [63:0] key;
    int          cnt;
    bit          lg;
    int          lim;
    int          st;
  } row_t;

  localparam logic [63:0] KA = 64'h7fffffffffffffff;
  localparam logic [63:0] KB = 64'h8000000000000002;

  logic                  clk_i, rst_ni, push, full, empty, pop;
  logic [1:0]            action_i;
  logic signed [63:0]    sequence_id_i;
  logic [COUNT_W-1:0]    page_count_i, list_limit_i;
  logic                  limit_given_i;
  logic [2:0]            status_o;
  logic                  page_valid_o, last_o, new_sequence_o;
  logic [PAGE_IDX_W-1:0] page_index_o;
  logic [FREE_W-1:0]     free_pages_o;
  logic [ACTIVE_W-1:0]   live_seqs_o;

  paged_sequence_page_allocator DUT (.*);

  // predictor state
  logic [9:0]  stk [NPG];
  int          stk_top;
  int          link [NPG];
  logic [63:0] skey [NSLOT];
  int          stotal [NSLOT], shead [NSLOT], stail [NSLOT];
  int          live;

  res_t        pending_beats [$];
  logic [63:0] pool [16];
  int          fails = 0;
  int          cycles = 0;
  int          burst_left = 1;
  int          pop_pct = 100;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int hash_slot(logic [63:0] x);
    x ^= x >> MIX_SHIFT;
    x = x * MIX_C1;
    x ^= x >> MIX_SHIFT;
    x = x * MIX_C2;
    x ^= x >> MIX_SHIFT;
    return int'(x % NSLOT);
  endfunction

  task automatic add_beat(status_e st, bit v, int pg, bit lst, bit nw);
    res_t r;
    r.status = st;
    r.page_valid = v;
    r.page_index = v ? pg[9:0] : '0;
    r.last = lst;
    r.new_sequence = nw;
    r.free_pages = stk_top[10:0];
    r.live_seqs = live[8:0];
    pending_beats.insert(pending_beats.size(), r);
  endtask

  task automatic table_reset();
    for (int i = 0; i < NPG; i++) begin
      stk[i] = 10'(NPG - 1 - i);
      link[i] = NPG;
    end
    stk_top = NPG;
    for (int s = 0; s < NSLOT; s++) begin
      skey[s] = KEY_EMPTY;
      stotal[s] = 0;
      shead[s] = NPG;
      stail[s] = NPG;
    end
    live = 0;
  endtask

  function automatic int lookup(logic [63:0] key);
    int idx;
    idx = hash_slot(key);
    for (int p = 0; p < NSLOT; p++) begin
      if (skey[idx] == key) return idx;
      if (skey[idx] == KEY_EMPTY) return -1;
      idx = (idx + 1) % NSLOT;
    end
    return -1;
  endfunction

  // Applies one request to the table model and queues its beats.
  task automatic allocate_model(action_e op, logic [63:0] key, int cnt, bit lg, int lim,
                                output status_e st);
    int s, idx, tomb, p, base, pg, nx, want, n;
    bit created;
    st = ST_OK;
    if (key == KEY_EMPTY || key == KEY_TOMB || op == ACT_BAD) begin
      st = ST_NOT_FOUND;
      add_beat(st, 0, 0, 1, 0);
      return;
    end
    if (op == ACT_ACQUIRE) begin
      if (cnt == 0) begin
        add_beat(ST_OK, 0, 0, 1, 0);
        return;
      end
      if (cnt > RUNMAX || stk_top < cnt) begin
        st = ST_TOO_FEW;
        add_beat(st, 0, 0, 1, 0);
        return;
      end
      idx = hash_slot(key);
      tomb = -1;
      s = -1;
      created = 0;
      for (p = 0; p < NSLOT; p++) begin
        if (skey[idx] == key) begin
          s = idx;
          break;
        end
        if (skey[idx] == KEY_EMPTY) break;
        if (skey[idx] == KEY_TOMB && tomb < 0) tomb = idx;
        idx = (idx + 1) % NSLOT;
      end
      if (s < 0) begin
        if (tomb >= 0) s = tomb;
        else if (p < NSLOT) s = idx;
        else begin
          st = ST_TABLE_FUL;
          add_beat(st, 0, 0, 1, 0);
          return;
        end
        skey[s] = key;
        stotal[s] = 0;
        shead[s] = NPG;
        stail[s] = NPG;
        created = 1;
        live++;
      end
      base = stk_top - cnt;
      stk_top = base;
      for (int i = 0; i < cnt; i++) begin
        pg = int'(stk[base + i]);
        link[pg] = NPG;
        if (shead[s] >= NPG) shead[s] = pg;
        else if (stail[s] < NPG) link[stail[s]] = pg;
        stail[s] = pg;
        stotal[s]++;
      end
      for (int i = 0; i < cnt; i++)
        add_beat(ST_OK, 1, int'(stk[base + i]), i + 1 == cnt, created);
      return;
    end
    s = lookup(key);
    if (s < 0) begin
      st = ST_NOT_FOUND;
      add_beat(st, 0, 0, 1, 0);
      return;
    end
    if (op == ACT_RELEASE) begin
      pg = shead[s];
      n = 0;
      while (pg < NPG && n < NPG) begin
        nx = link[pg];
        link[pg] = NPG;
        if (stk_top < NPG) begin
          stk[stk_top] = pg[9:0];
          stk_top++;
        end
        pg = nx;
        n++;
      end
      skey[s] = KEY_TOMB;
      stotal[s] = 0;
      shead[s] = NPG;
      stail[s] = NPG;
      if (live > 0) live--;
      add_beat(ST_OK, 0, 0, 1, 0);
      return;
    end
    if (lg && lim > stotal[s]) begin
      st = ST_LIMIT;
      add_beat(st, 0, 0, 1, 0);
      return;
    end
    want = lg ? lim : stotal[s];
    if (want > RUNMAX) want = RUNMAX;
    pg = shead[s];
    n = 0;
    while (pg < NPG && n < want) begin
      add_beat(ST_OK, 1, pg, 0, 0);
      pg = link[pg];
      n++;
    end
    if (n == 0) add_beat(ST_OK, 0, 0, 1, 0);
    else pending_beats[pending_beats.size() - 1].last = 1;
  endtask

  // One request beat through push/full, with bursty pacing.
  task automatic push_request(action_e op, logic [63:0] key, int cnt, bit lg, int lim);
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    push <= 1'b1;
    action_i <= op;
    sequence_id_i <= key;
    page_count_i <= cnt[6:0];
    limit_given_i <= lg;
    list_limit_i <= lim[6:0];
    do @(posedge clk_i); while (full);
  endtask

  task automatic run_request(action_e op, logic [63:0] key, int cnt, bit lg, int lim,
                             output status_e st);
    push_request(op, key, cnt, lg, lim);
    allocate_model(op, key, cnt, lg, lim, st);
  endtask

  // result side
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni) begin
      if (pop && !empty) begin
        got.status = status_e'(status_o);
        got.page_valid = page_valid_o;
        got.page_index = page_index_o;
        got.last = last_o;
        got.new_sequence = new_sequence_o;
        got.free_pages = free_pages_o;
        got.live_seqs = live_seqs_o;
        if (pending_beats.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected beat %p", got);
        end else begin
          want = pending_beats.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) $display("beat mismatch: exp %p got %p", want, got);
          end
        end
      end
      if (cycles % 300 == 0) pop_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(5, 90);
      pop <= ($urandom_range(0, 99) < pop_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  row_t dir_rows [20] = '{
    '{ACT_LIST,    KA, 0, 0, 0, ST_NOT_FOUND},
    '{ACT_RELEASE, KA, 0, 0, 0, ST_NOT_FOUND},
    '{ACT_ACQUIRE, KA, 0, 0, 0, ST_OK},
    '{ACT_ACQUIRE, KA, 65, 0, 0, ST_TOO_FEW},
    '{ACT_ACQUIRE, KA, 127, 1, 127, ST_TOO_FEW},
    '{ACT_ACQUIRE, KEY_EMPTY, 3, 0, 0, ST_NOT_FOUND},
    '{ACT_ACQUIRE, KEY_TOMB, 3, 0, 0, ST_NOT_FOUND},
    '{ACT_BAD,     KA, 1, 0, 0, ST_NOT_FOUND},
    '{ACT_ACQUIRE, KA, 64, 0, 0, NONE},
    '{ACT_ACQUIRE, KB, 1, 0, 0, NONE},
    '{ACT_ACQUIRE, KA, 2, 0, 0, NONE},
    '{ACT_LIST,    KA, 0, 0, 0, NONE},
    '{ACT_LIST,    KA, 0, 1, 64, NONE},
    '{ACT_LIST,    KA, 0, 1, 67, ST_LIMIT},
    '{ACT_LIST,    KB, 0, 1, 0, NONE},
    '{ACT_RELEASE, KA, 0, 0, 0, ST_OK},
    '{ACT_LIST,    KA, 127, 1, 127, ST_NOT_FOUND},
    '{ACT_ACQUIRE, KA, 5, 0, 0, NONE},
    '{ACT_RELEASE, KB, 0, 0, 0, NONE},
    '{ACT_RELEASE, KA, 0, 0, 0, NONE}
  };

  initial begin
    status_e st;
    logic [63:0] key;
    action_e op;
    int pick, cnt, lim;
    bit lg;
    push = 0; pop = 0; action_i = '0; sequence_id_i = '0;
    page_count_i = '0; limit_given_i = 0; list_limit_i = '0;
    rst_ni = 0;
    table_reset();
    for (int i = 0; i < 16; i++) pool[i] = {$urandom, $urandom};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // typed status on the row's single beat; counts come from the table model
    foreach (dir_rows[i]) begin
      push_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].cnt, dir_rows[i].lg,
                   dir_rows[i].lim);
      allocate_model(dir_rows[i].op, dir_rows[i].key, dir_rows[i].cnt, dir_rows[i].lg,
                     dir_rows[i].lim, st);
      if (dir_rows[i].st != NONE)
        pending_beats[pending_beats.size() - 1].status = status_e'(dir_rows[i].st);
    end

    for (int i = 0; i < 160; i++) begin
      if (i == 80) begin
        push <= 1'b0;
        wait (pending_beats.size() == 0);
        @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      op = pick < 45 ? ACT_ACQUIRE : pick < 63 ? ACT_RELEASE : pick < 96 ? ACT_LIST : ACT_BAD;
      key = pool[$urandom_range(0, 15)];
      pick = $urandom_range(0, 99);
      if (pick < 3) key = KEY_EMPTY;
      else if (pick < 6) key = KEY_TOMB;
      else if (pick < 10) key = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      cnt = pick < 6 ? $urandom_range(1, 8) : pick < 9 ? $urandom_range(0, 64)
          : $urandom_range(0, 127);
      lg = $urandom_range(0, 1);
      lim = $urandom_range(0, 4) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 12);
      run_request(op, key, cnt, lg, lim, st);
    end

    // hand the pool's pages back, then fill the sequence table until it reports full
    for (int i = 0; i < 16; i++) run_request(ACT_RELEASE, pool[i], 0, 0, 0, st);
    for (int i = 0; i < NSLOT + 8; i++) begin
      key = {1'b0, 31'($urandom), $urandom};
      run_request(ACT_ACQUIRE, key, 1, 0, 0, st);
      if (st == ST_TABLE_FUL) break;
    end

    push <= 1'b0;
    wait (pending_beats.size() == 0);
    repeat (300) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
